[sv/esc_pkg.sv]
// Shared types and constants of the elevator scan controller.
`default_nettype none

package esc_pkg;

  localparam int unsigned FLOOR_W = 5;
  localparam int unsigned CMD_W   = 2;
  localparam int unsigned HEAD_W  = 2;

  localparam logic [FLOOR_W-1:0] NUM_FLOORS_RST = 5'd10;

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK    = 2'd0,
    CMD_HALL_UP = 2'd1,
    CMD_HALL_DN = 2'd2,
    CMD_CAR     = 2'd3
  } cmd_e;

  typedef enum logic [HEAD_W-1:0] {
    DIR_IDLE = 2'd0,
    DIR_UP   = 2'd1,
    DIR_DOWN = 2'd2
  } dir_e;

  // Start request for one floor scan.
  typedef struct packed {
    logic start;
    logic up;
    logic empty;
  } scan_cmd_t;

  // Hit flags of a finished scan: first primary, first secondary, last tertiary.
  typedef struct packed {
    logic p;
    logic s;
    logic t;
  } scan_hit_t;

endpackage

`default_nettype wire

[sv/elevator_scan_controller_core.sv]
// Top level of the single-car elevator scan controller.
//
// Input words (cmd_i, floor_i) enter on in_valid_i / in_stall_o; every word
// yields exactly one result word on out_valid_o / out_stall_i. A request word
// sets one bit in the hall up, hall down or car call map, or flags bad_floor_o.
// A tick word serves the calls of at most one floor by a floor-by-floor scan.
// A request word goes to S_FIN, which loads its result once the output is free.
// A tick walks the floors one per cycle in a shared scan unit: one pass from
// the car toward the end of travel when moving, two passes (up, then down)
// when idle, over a call map of MAX_FLOORS entries (MAX_FLOORS capped at 32).
// One word is in work at a time; in_stall_o stays high until its result has
// been placed in the output register, so the next word can enter while a
// result waits. A stalled result holds its value. The num_floors register is
// written over cfg_valid_i / cfg_ready_o while the block is idle and drops
// calls above the new top floor. Reset puts the car at floor 1, idle, with no
// calls pending and num_floors at 10.
`default_nettype none

module elevator_scan_controller_core import esc_pkg::*; #(
  parameter int unsigned MAX_FLOORS = 32
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [CMD_W-1:0]   cmd_i,
  input  wire logic [FLOOR_W-1:0] floor_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic [FLOOR_W-1:0]      floor_now_o,
  output logic [HEAD_W-1:0]       heading_o,
  output logic                    moved_o,
  output logic                    bad_floor_o,
  output logic                    any_pending_o,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [FLOOR_W-1:0] cfg_num_floors_i
);

  // Floor numbers never exceed the 5-bit field, so at most 32 map entries are live.
  localparam int unsigned NMAP = (MAX_FLOORS > 32) ? 32 : MAX_FLOORS;
  localparam int unsigned IW   = $clog2(NMAP);
  localparam logic [FLOOR_W:0] MAX_TOP_W = (FLOOR_W + 1)'(NMAP - 1);

  typedef enum logic [3:0] {
    S_READY = 4'b0001,
    S_SCAN  = 4'b0010,
    S_SCAN2 = 4'b0100,
    S_FIN   = 4'b1000
  } state_e;

  state_e               state_q, state_d;
  logic [FLOOR_W-1:0]   nf_q, nf_d;
  logic [IW-1:0]        car_q, car_d;
  dir_e                 dir_q, dir_d;
  dir_e                 mode_q, mode_d;
  logic [NMAP-1:0]      hu_q, hu_d;
  logic [NMAP-1:0]      hd_q, hd_d;
  logic [NMAP-1:0]      cc_q, cc_d;
  logic                 moved_q, moved_d;
  logic                 bad_q, bad_d;
  logic                 uh_vld_q, uh_vld_d;
  logic [IW-1:0]        uh_idx_q, uh_idx_d;
  logic                 above_q, above_d;

  logic                 ovld_q, ovld_d;
  logic [FLOOR_W-1:0]   o_floor_q, o_floor_d;
  logic [HEAD_W-1:0]    o_head_q, o_head_d;
  logic                 o_moved_q, o_moved_d;
  logic                 o_bad_q, o_bad_d;
  logic                 o_any_q, o_any_d;

  logic [IW-1:0]        top;
  logic                 any_req;
  logic                 in_acc;
  logic                 cfg_acc;
  logic                 out_free;
  logic                 fl_ok;
  logic [IW-1:0]        car_m1;
  logic [IW-1:0]        dist_up;
  logic [IW-1:0]        dist_dn;
  logic [NMAP-1:0]      keep;

  scan_cmd_t            scmd;
  logic                 s_start;
  logic [IW:0]          s_from;
  logic [IW-1:0]        s_to;
  logic                 s_bit_p, s_bit_s, s_bit_t;
  logic [IW:0]          s_idx;
  logic [IW-1:0]        s_ridx;
  logic                 s_done;
  scan_hit_t            s_hit;
  logic [IW-1:0]        s_p_idx, s_s_idx, s_t_idx;

  assign top = ({1'b0, nf_q} > MAX_TOP_W) ? IW'(NMAP - 1) : nf_q[IW-1:0];
  assign any_req  = |(hu_q | hd_q | cc_q);
  assign in_stall_o  = (state_q != S_READY);
  assign cfg_ready_o = (state_q == S_READY);
  assign in_acc   = in_valid_i && !in_stall_o;
  assign cfg_acc  = cfg_valid_i && cfg_ready_o;
  assign out_free = !ovld_q || !out_stall_i;
  assign fl_ok    = (floor_i != '0) &&
                    ({1'b0, floor_i} <= (FLOOR_W + 1)'(top));
  assign car_m1   = car_q - IW'(1);
  assign dist_up  = uh_idx_q - car_q;
  assign dist_dn  = car_q - s_p_idx;
  assign s_ridx   = s_idx[IW-1:0];

  always_comb begin
    for (int i = 0; i < NMAP; i++) begin
      keep[i] = ((FLOOR_W + 1)'(i) <= {1'b0, cfg_num_floors_i});
    end
  end

  // Scan range for the pass that starts this cycle.
  always_comb begin
    scmd.start = s_start;
    scmd.up    = 1'b1;
    scmd.empty = 1'b0;
    s_from     = {1'b0, car_q};
    s_to       = top;
    if (state_q == S_SCAN) begin
      // Second pass of an idle tick: downward from the car, clipped to the top.
      scmd.up = 1'b0;
      s_from  = (car_q > top) ? {1'b0, top} : {1'b0, car_q};
      s_to    = '0;
    end else begin
      case (dir_q)
        DIR_UP: begin
          s_from     = {1'b0, car_q} + 1'b1;
          scmd.empty = (car_q >= top);
        end
        DIR_DOWN: begin
          scmd.up    = 1'b0;
          s_from     = (car_m1 > top) ? {1'b0, top} : {1'b0, car_m1};
          s_to       = '0;
          scmd.empty = (car_q == '0);
        end
        default: begin
          scmd.empty = (car_q > top);
        end
      endcase
    end
  end

  // Map selection feeding the scan unit for each pass and direction.
  always_comb begin
    s_bit_p = 1'b0;
    s_bit_s = 1'b0;
    s_bit_t = 1'b0;
    if (state_q == S_SCAN2) begin
      s_bit_p = hd_q[s_ridx] | cc_q[s_ridx];
    end else begin
      case (mode_q)
        DIR_UP: begin
          s_bit_p = cc_q[s_ridx];
          s_bit_s = hu_q[s_ridx];
          s_bit_t = hd_q[s_ridx];
        end
        DIR_DOWN: begin
          s_bit_p = cc_q[s_ridx];
          s_bit_s = hd_q[s_ridx];
          s_bit_t = hu_q[s_ridx];
        end
        default: begin
          s_bit_p = hu_q[s_ridx] | cc_q[s_ridx];
          s_bit_t = hd_q[s_ridx];
        end
      endcase
    end
  end

  always_comb begin
    state_d   = state_q;
    nf_d      = nf_q;
    car_d     = car_q;
    dir_d     = dir_q;
    mode_d    = mode_q;
    hu_d      = hu_q;
    hd_d      = hd_q;
    cc_d      = cc_q;
    moved_d   = moved_q;
    bad_d     = bad_q;
    uh_vld_d  = uh_vld_q;
    uh_idx_d  = uh_idx_q;
    above_d   = above_q;
    s_start   = 1'b0;
    ovld_d    = ovld_q && out_stall_i;
    o_floor_d = o_floor_q;
    o_head_d  = o_head_q;
    o_moved_d = o_moved_q;
    o_bad_d   = o_bad_q;
    o_any_d   = o_any_q;

    case (state_q)
      S_READY: begin
        if (in_acc) begin
          moved_d = 1'b0;
          bad_d   = 1'b0;
          state_d = S_FIN;
          if (cmd_e'(cmd_i) == CMD_TICK) begin
            if (!any_req) begin
              dir_d = DIR_IDLE;
            end else begin
              mode_d  = dir_q;
              s_start = 1'b1;
              state_d = S_SCAN;
            end
          end else if (!fl_ok) begin
            bad_d = 1'b1;
          end else begin
            case (cmd_e'(cmd_i))
              CMD_HALL_UP: hu_d[floor_i[IW-1:0]] = 1'b1;
              CMD_HALL_DN: hd_d[floor_i[IW-1:0]] = 1'b1;
              default:     cc_d[floor_i[IW-1:0]] = 1'b1;
            endcase
          end
        end
      end
      S_SCAN: begin
        if (s_done) begin
          state_d = S_FIN;
          case (mode_q)
            DIR_UP: begin
              if (s_hit.p) begin
                car_d = s_p_idx;
                cc_d[s_p_idx] = 1'b0;
                moved_d = 1'b1;
              end else if (s_hit.s) begin
                car_d = s_s_idx;
                hu_d[s_s_idx] = 1'b0;
                moved_d = 1'b1;
              end else if (s_hit.t) begin
                dir_d = DIR_DOWN;
                car_d = s_t_idx;
                hd_d[s_t_idx] = 1'b0;
                moved_d = 1'b1;
              end else begin
                dir_d = DIR_DOWN;
              end
            end
            DIR_DOWN: begin
              if (s_hit.p) begin
                car_d = s_p_idx;
                cc_d[s_p_idx] = 1'b0;
                moved_d = 1'b1;
              end else if (s_hit.s) begin
                car_d = s_s_idx;
                hd_d[s_s_idx] = 1'b0;
                moved_d = 1'b1;
              end else if (s_hit.t) begin
                dir_d = DIR_UP;
                car_d = s_t_idx;
                hu_d[s_t_idx] = 1'b0;
                moved_d = 1'b1;
              end else begin
                dir_d = DIR_UP;
              end
            end
            default: begin
              // Idle: keep the upward result and run the downward pass.
              uh_vld_d = s_hit.p;
              uh_idx_d = s_p_idx;
              above_d  = s_hit.t;
              s_start  = 1'b1;
              state_d  = S_SCAN2;
            end
          endcase
        end
      end
      S_SCAN2: begin
        if (s_done) begin
          state_d = S_FIN;
          if (uh_vld_q && (!s_hit.p || (dist_up <= dist_dn))) begin
            dir_d = DIR_UP;
            car_d = uh_idx_q;
            hu_d[uh_idx_q] = 1'b0;
            cc_d[uh_idx_q] = 1'b0;
            moved_d = 1'b1;
          end else if (s_hit.p) begin
            dir_d = DIR_DOWN;
            car_d = s_p_idx;
            hd_d[s_p_idx] = 1'b0;
            cc_d[s_p_idx] = 1'b0;
            moved_d = 1'b1;
          end else begin
            // Only down calls above or up calls below: head toward them.
            dir_d = above_q ? DIR_UP : DIR_DOWN;
          end
        end
      end
      S_FIN: begin
        if (out_free) begin
          ovld_d    = 1'b1;
          o_floor_d = FLOOR_W'(car_q);
          o_head_d  = dir_q;
          o_moved_d = moved_q;
          o_bad_d   = bad_q;
          o_any_d   = any_req;
          state_d   = S_READY;
        end
      end
      default: begin
        state_d = S_READY;
      end
    endcase

    if (cfg_acc) begin
      nf_d = cfg_num_floors_i;
      hu_d = hu_d & keep;
      hd_d = hd_d & keep;
      cc_d = cc_d & keep;
    end
  end

  esc_scan #(
    .IW (IW)
  ) u_scan (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (scmd),
    .from_i  (s_from),
    .to_i    (s_to),
    .bit_p_i (s_bit_p),
    .bit_s_i (s_bit_s),
    .bit_t_i (s_bit_t),
    .idx_o   (s_idx),
    .done_o  (s_done),
    .hit_o   (s_hit),
    .p_idx_o (s_p_idx),
    .s_idx_o (s_s_idx),
    .t_idx_o (s_t_idx)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_READY;
      nf_q    <= NUM_FLOORS_RST;
      car_q   <= IW'(1);
      dir_q   <= DIR_IDLE;
      mode_q  <= DIR_IDLE;
      hu_q    <= '0;
      hd_q    <= '0;
      cc_q    <= '0;
      ovld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      nf_q    <= nf_d;
      car_q   <= car_d;
      dir_q   <= dir_d;
      mode_q  <= mode_d;
      hu_q    <= hu_d;
      hd_q    <= hd_d;
      cc_q    <= cc_d;
      ovld_q  <= ovld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    moved_q   <= moved_d;
    bad_q     <= bad_d;
    uh_vld_q  <= uh_vld_d;
    uh_idx_q  <= uh_idx_d;
    above_q   <= above_d;
    o_floor_q <= o_floor_d;
    o_head_q  <= o_head_d;
    o_moved_q <= o_moved_d;
    o_bad_q   <= o_bad_d;
    o_any_q   <= o_any_d;
  end

  assign out_valid_o   = ovld_q;
  assign floor_now_o   = o_floor_q;
  assign heading_o     = o_head_q;
  assign moved_o       = o_moved_q;
  assign bad_floor_o   = o_bad_q;
  assign any_pending_o = o_any_q;

endmodule

`default_nettype wire

[sv/esc_scan.sv]
// Floor-by-floor scan unit that walks an index range and records request hits.
`default_nettype none

module esc_scan import esc_pkg::*; #(
  parameter int unsigned IW = 5
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire scan_cmd_t     cmd_i,
  input  wire logic [IW:0]   from_i,
  input  wire logic [IW-1:0] to_i,
  input  wire logic          bit_p_i,
  input  wire logic          bit_s_i,
  input  wire logic          bit_t_i,
  output logic [IW:0]        idx_o,
  output logic               done_o,
  output scan_hit_t          hit_o,
  output logic [IW-1:0]      p_idx_o,
  output logic [IW-1:0]      s_idx_o,
  output logic [IW-1:0]      t_idx_o
);

  logic          busy_q, busy_d;
  logic          up_q, up_d;
  logic          done_q, done_d;
  logic [IW:0]   idx_q, idx_d;
  logic [IW-1:0] to_q, to_d;
  scan_hit_t     hit_q, hit_d;
  logic [IW-1:0] p_idx_q, p_idx_d;
  logic [IW-1:0] s_idx_q, s_idx_d;
  logic [IW-1:0] t_idx_q, t_idx_d;
  logic          last_step;

  assign last_step = (idx_q == {1'b0, to_q});

  always_comb begin
    busy_d  = busy_q;
    up_d    = up_q;
    idx_d   = idx_q;
    to_d    = to_q;
    hit_d   = hit_q;
    p_idx_d = p_idx_q;
    s_idx_d = s_idx_q;
    t_idx_d = t_idx_q;
    done_d  = 1'b0;
    if (cmd_i.start) begin
      busy_d = !cmd_i.empty;
      done_d = cmd_i.empty;
      up_d   = cmd_i.up;
      idx_d  = from_i;
      to_d   = to_i;
      hit_d  = '0;
    end else if (busy_q) begin
      // The first hit wins for the primary and secondary maps, the last for the tertiary.
      if (bit_p_i && !hit_q.p) begin
        hit_d.p = 1'b1;
        p_idx_d = idx_q[IW-1:0];
      end
      if (bit_s_i && !hit_q.s) begin
        hit_d.s = 1'b1;
        s_idx_d = idx_q[IW-1:0];
      end
      if (bit_t_i) begin
        hit_d.t = 1'b1;
        t_idx_d = idx_q[IW-1:0];
      end
      if (last_step) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else if (up_q) begin
        idx_d = idx_q + 1'b1;
      end else begin
        idx_d = idx_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    up_q    <= up_d;
    idx_q   <= idx_d;
    to_q    <= to_d;
    hit_q   <= hit_d;
    p_idx_q <= p_idx_d;
    s_idx_q <= s_idx_d;
    t_idx_q <= t_idx_d;
  end

  assign idx_o   = idx_q;
  assign done_o  = done_q;
  assign hit_o   = hit_q;
  assign p_idx_o = p_idx_q;
  assign s_idx_o = s_idx_q;
  assign t_idx_o = t_idx_q;

endmodule

`default_nettype wire
